// ===== hdl/ftm_pkg.sv =====
package ftm_pkg;

  localparam int unsigned DATA_W  = 16;
  localparam int unsigned QUO_W   = 15;
  localparam int unsigned N_CELLS = QUO_W;

  localparam logic [DATA_W-1:0] ONE_Q15 = 16'h8000;

  typedef enum logic {
    SHAPE_TRIANGLE  = 1'b0,
    SHAPE_TRAPEZOID = 1'b1
  } shape_e;

  // Word handed from cell to cell. A sample on a plateau or a peak sets full.
  // The remainder always stays below the divisor.
  typedef struct packed {
    logic              full;
    logic [DATA_W-1:0] rem;
    logic [DATA_W-1:0] div;
    logic [QUO_W-1:0]  quo;
  } cell_t;

endpackage

// ===== hdl/ftm_front.sv =====
module ftm_front
  import ftm_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  shape_e                   shape_i,
  input  logic signed [DATA_W-1:0] x_i,
  input  logic signed [DATA_W-1:0] a_i,
  input  logic signed [DATA_W-1:0] b_i,
  input  logic signed [DATA_W-1:0] c_i,
  input  logic signed [DATA_W-1:0] d_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output cell_t                    data_o
);

  logic                     valid_q;
  cell_t                    data_q, data_d;
  logic signed [DATA_W-1:0] shoulder_r, foot_r;
  logic signed [DATA_W:0]   rise_up, width_up, rise_dn, width_dn;

  // A triangle is a trapezoid whose two shoulders coincide at the peak.
  assign shoulder_r = (shape_i == SHAPE_TRAPEZOID) ? c_i : b_i;
  assign foot_r     = (shape_i == SHAPE_TRAPEZOID) ? d_i : c_i;

  assign rise_up  = {x_i[DATA_W-1], x_i} - {a_i[DATA_W-1], a_i};
  assign width_up = {b_i[DATA_W-1], b_i} - {a_i[DATA_W-1], a_i};
  assign rise_dn  = {foot_r[DATA_W-1], foot_r} - {x_i[DATA_W-1], x_i};
  assign width_dn = {foot_r[DATA_W-1], foot_r} - {shoulder_r[DATA_W-1], shoulder_r};

  always_comb begin
    data_d.full = 1'b0;
    data_d.rem  = '0;
    data_d.div  = DATA_W'(1);
    data_d.quo  = '0;
    priority if (x_i >= b_i && x_i <= shoulder_r) begin
      data_d.full = 1'b1;
    end else if (x_i <= a_i || x_i >= foot_r) begin
      data_d.full = 1'b0;
    end else if (x_i < b_i) begin
      // On a slope the rise is positive and smaller than the width.
      data_d.rem = rise_up[DATA_W-1:0];
      data_d.div = width_up[DATA_W-1:0];
    end else begin
      data_d.rem = rise_dn[DATA_W-1:0];
      data_d.div = width_dn[DATA_W-1:0];
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

// ===== hdl/ftm_cell.sv =====
module ftm_cell
  import ftm_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  cell_t data_i,
  output logic  valid_o,
  input  logic  ready_i,
  output cell_t data_o
);

  logic              valid_q;
  cell_t             data_q, data_d;
  logic [DATA_W:0]   twice;
  logic [DATA_W:0]   diff;
  logic              ge;

  // One restoring division step: double the remainder, subtract if it fits.
  assign twice = {data_i.rem, 1'b0};
  assign diff  = twice - {1'b0, data_i.div};
  assign ge    = twice >= {1'b0, data_i.div};

  always_comb begin
    data_d      = data_i;
    data_d.rem  = ge ? diff[DATA_W-1:0] : twice[DATA_W-1:0];
    data_d.quo  = {data_i.quo[QUO_W-2:0], ge};
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

// ===== hdl/fuzzy_trapezoid_membership_top.sv =====
// Fuzzy membership evaluator for triangle and trapezoid sets. Each transfer
// on the input stream carries one signed 16-bit sample and four signed
// breakpoints; the shape is chosen per transfer by tuser (0 triangle using
// points one to three, 1 trapezoid using all four). Each input transfer
// yields exactly one output transfer holding the membership degree as
// unsigned Q1.15, where 32768 is 1.0. On a slope the degree is the rise
// divided by the slope width, truncated toward zero. The block takes one
// transfer per clock cycle unless a full row stalls. It has one stage that
// classifies the sample and forms the rise and width, then a row of 15
// identical cells, each of which resolves one quotient bit. Every stage holds
// its item until the next one has room, so the input keeps accepting while
// results wait on a stalled output, until the whole row is full.
module fuzzy_trapezoid_membership_top
  import ftm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // Fields from bit 0: sample, point_one, point_two, point_three, point_four.
  input  logic [79:0] s_axis_tdata_i,
  // Fields from bit 0: shape.
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // Fields from bit 0: degree.
  output logic [15:0] m_axis_tdata_o
);

  logic  [N_CELLS:0] valid_c;
  logic  [N_CELLS:0] ready_c;
  cell_t             data_c [N_CELLS+1];
  cell_t             last_w;

  // Front stage: compares and subtractions for the shape, registered.
  ftm_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .shape_i (shape_e'(s_axis_tuser_i)),
    .x_i     (s_axis_tdata_i[15:0]),
    .a_i     (s_axis_tdata_i[31:16]),
    .b_i     (s_axis_tdata_i[47:32]),
    .c_i     (s_axis_tdata_i[63:48]),
    .d_i     (s_axis_tdata_i[79:64]),
    .valid_o (valid_c[0]),
    .ready_i (ready_c[0]),
    .data_o  (data_c[0])
  );

  // Division row: cell i hands its partial quotient to cell i+1 when that cell has room.
  for (genvar gi = 0; gi < N_CELLS; gi++) begin : g_cell
    ftm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_c[gi]),
      .ready_o (ready_c[gi]),
      .data_i  (data_c[gi]),
      .valid_o (valid_c[gi+1]),
      .ready_i (ready_c[gi+1]),
      .data_o  (data_c[gi+1])
    );
  end

  // The last cell's register is the output register.
  assign ready_c[N_CELLS] = m_axis_tready_i;
  assign last_w           = data_c[N_CELLS];
  assign m_axis_tvalid_o  = valid_c[N_CELLS];
  assign m_axis_tdata_o   = last_w.full ? ONE_Q15 : {1'b0, last_w.quo};

`ifndef SYNTHESIS
  // The degree can never exceed one.
  a_degree_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o <= ONE_Q15))
    else $error("degree above one");

  // Every item entering the division row has a partial remainder below a
  // nonzero divisor, so each cell yields a single quotient bit.
  a_front_rem : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_c[0] |-> (data_c[0].div != '0 && data_c[0].rem < data_c[0].div))
    else $error("front stage remainder not below divisor");

  // A saturated result never carries quotient bits.
  a_full_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && last_w.full) |-> (last_w.quo == '0))
    else $error("plateau result with quotient bits");

  // The input only stalls when every stage holds an item.
  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (&valid_c))
    else $error("input stalled with a free stage");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import ftm_pkg::*;

  localparam int CLK_HALF_NS    = 4;
  localparam int RESET_CYCLES   = 4;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_OFF_LONG  = 300;
  localparam int DRAIN_CYCLES   = 24;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  // Degrees predicted for accepted samples, oldest first.
  logic [15:0] degree_queue[$];
  logic [15:0] expected_degree;
  int          mismatch_count = 0;
  int          idle_cycles = 0;
  int          stall_left = 0;
  int          hold_request = 0;
  bit          send_steady = 1'b0;
  bit          recv_steady = 1'b0;

  fuzzy_trapezoid_membership_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  always #(CLK_HALF_NS) clk_i = ~clk_i;

  // Rise over width as Q1.15, truncated, clamped to one; nothing for a flat slope.
  function automatic logic [15:0] slope_fraction(int rise, int width);
    longint q;
    if (width <= 0 || rise <= 0) begin
      return '0;
    end
    q = (longint'(rise) * longint'(ONE_Q15)) / longint'(width);
    if (q > longint'(ONE_Q15)) begin
      q = longint'(ONE_Q15);
    end
    return q[15:0];
  endfunction

  function automatic logic [15:0] membership_degree(shape_e shape, logic signed [15:0] x,
                                                    logic signed [15:0] a, logic signed [15:0] b,
                                                    logic signed [15:0] c, logic signed [15:0] d);
    int xi, ai, bi, ci, di;
    xi = int'(x);
    ai = int'(a);
    bi = int'(b);
    ci = int'(c);
    di = int'(d);
    if (shape == SHAPE_TRAPEZOID) begin
      // The plateau wins even when the points are out of order.
      if (xi >= bi && xi <= ci) begin
        return ONE_Q15;
      end
      if (xi <= ai || xi >= di) begin
        return '0;
      end
      if (xi < bi) begin
        return slope_fraction(xi - ai, bi - ai);
      end
      return slope_fraction(di - xi, di - ci);
    end
    // Triangle: hitting the peak wins over the feet.
    if (xi == bi) begin
      return ONE_Q15;
    end
    if (xi <= ai || xi >= ci) begin
      return '0;
    end
    if (xi < bi) begin
      return slope_fraction(xi - ai, bi - ai);
    end
    return slope_fraction(ci - xi, ci - bi);
  endfunction

  // Mostly back to back, often a short gap, now and then a long pause.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      return 0;
    end
    if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic int clamp16(int v);
    if (v > 32767) begin
      return 32767;
    end
    if (v < -32768) begin
      return -32768;
    end
    return v;
  endfunction

  // Every accepted transfer gets its prediction queued at the edge that takes it.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      degree_queue.push_back(membership_degree(shape_e'(s_axis_tuser), s_axis_tdata[15:0],
                                               s_axis_tdata[31:16], s_axis_tdata[47:32],
                                               s_axis_tdata[63:48], s_axis_tdata[79:64]));
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (degree_queue.size() == 0) begin
        $display("%0t: unexpected degree %0d with nothing expected", $time, m_axis_tdata);
        mismatch_count++;
      end else begin
        expected_degree = degree_queue.pop_front();
        if (m_axis_tdata !== expected_degree) begin
          $display("%0t: degree mismatch, expected %0d, got %0d", $time, expected_degree,
                   m_axis_tdata);
          mismatch_count++;
        end
      end
    end
  end

  // Stall counter for the output side; a hold-off request overrides the random pattern.
  always @(posedge clk_i) begin
    if (hold_request > 0) begin
      stall_left = hold_request;
      hold_request = 0;
    end
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
      if (!recv_steady) begin
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Offers one sample and returns at the edge where it is taken. Valid stays high so
  // that a following call can present the next sample without a bubble.
  task automatic send_item(shape_e shape, logic signed [15:0] x, logic signed [15:0] a,
                           logic signed [15:0] b, logic signed [15:0] c,
                           logic signed [15:0] d);
    int gap;
    gap = send_steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {d, c, b, a, x};
    s_axis_tuser  <= shape;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (degree_queue.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Breakpoints are usually sorted and clustered so that all regions get hit; the
  // sample lands on, next to, between them or anywhere. The rest is plain noise.
  task automatic send_random_item();
    int     pts[$];
    int     center, span, lo, hi, k, x;
    shape_e shape;
    logic [15:0] raw[5];
    shape = shape_e'($urandom_range(0, 1));
    if ($urandom_range(0, 9) < 7) begin
      center = int'($urandom_range(0, 65535)) - 32768;
      case ($urandom_range(0, 2))
        0: span = $urandom_range(0, 8);
        1: span = $urandom_range(0, 300);
        default: span = 65535;
      endcase
      lo = clamp16(center - span);
      hi = clamp16(center + span);
      pts = {};
      repeat (4) pts.push_back(int'($urandom_range(0, hi - lo)) + lo);
      pts.sort();
      case ($urandom_range(0, 3))
        0: x = pts[$urandom_range(0, 3)];
        1: begin
          k = $urandom_range(0, 3);
          x = clamp16(pts[k] + int'($urandom_range(0, 2)) - 1);
        end
        2: x = int'($urandom_range(0, pts[3] - pts[0])) + pts[0];
        default: x = int'($urandom_range(0, 65535)) - 32768;
      endcase
      // A triangle ignores point four, so give that field random bits.
      if (shape == SHAPE_TRIANGLE) begin
        pts[3] = int'($urandom_range(0, 65535)) - 32768;
      end
      send_item(shape, 16'(x), 16'(pts[0]), 16'(pts[1]), 16'(pts[2]), 16'(pts[3]));
    end else begin
      foreach (raw[i]) raw[i] = 16'($urandom_range(0, 65535));
      send_item(shape, raw[0], raw[1], raw[2], raw[3], raw[4]);
    end
  endtask

  task automatic test_directed();
    // Triangle: peak, peak behind a foot, both feet, both slopes.
    send_item(SHAPE_TRIANGLE, 0, -100, 0, 100, 0);
    send_item(SHAPE_TRIANGLE, -150, -100, -150, 100, 0);
    send_item(SHAPE_TRIANGLE, -100, -100, 0, 100, 0);
    send_item(SHAPE_TRIANGLE, 100, -100, 0, 100, 0);
    send_item(SHAPE_TRIANGLE, -50, -100, 0, 100, 0);
    send_item(SHAPE_TRIANGLE, 33, -100, 0, 100, 16'hffff);
    // Full-scale slopes need the wide product; a rise of one truncates to zero.
    send_item(SHAPE_TRIANGLE, 32766, -32768, 32767, 32767, 0);
    send_item(SHAPE_TRIANGLE, -32767, -32768, 32767, 32767, 0);
    send_item(SHAPE_TRIANGLE, -32767, -32768, -32768, 32767, -32768);
    // Unordered and collapsed triangles.
    send_item(SHAPE_TRIANGLE, 10, 50, -50, 0, 0);
    send_item(SHAPE_TRIANGLE, -20, 50, -50, 0, 0);
    send_item(SHAPE_TRIANGLE, 5, 5, 5, 5, 5);
    send_item(SHAPE_TRIANGLE, 6, 5, 5, 5, 5);
    // Trapezoid: plateau and its edges, both slopes, both feet.
    send_item(SHAPE_TRAPEZOID, 0, -100, -10, 10, 100);
    send_item(SHAPE_TRAPEZOID, -10, -100, -10, 10, 100);
    send_item(SHAPE_TRAPEZOID, 10, -100, -10, 10, 100);
    send_item(SHAPE_TRAPEZOID, -55, -100, -10, 10, 100);
    send_item(SHAPE_TRAPEZOID, 55, -100, -10, 10, 100);
    send_item(SHAPE_TRAPEZOID, -100, -100, -10, 10, 100);
    send_item(SHAPE_TRAPEZOID, 100, -100, -10, 10, 100);
    // Plateau past the right foot, and shoulders that cross with no plateau.
    send_item(SHAPE_TRAPEZOID, 30, 0, -50, 50, 20);
    send_item(SHAPE_TRAPEZOID, 0, -100, 20, -20, 100);
    send_item(SHAPE_TRAPEZOID, 50, -100, 20, -20, 100);
    // Extremes of the sample and the points.
    send_item(SHAPE_TRAPEZOID, -32768, -32768, -32768, -32768, -32768);
    send_item(SHAPE_TRAPEZOID, 32767, -32768, -32768, -32768, 32767);
    send_item(SHAPE_TRAPEZOID, -32767, -32768, -32768, -32768, 32767);
    drain_results();
  endtask

  task automatic test_random_mix(int count);
    repeat (count) send_random_item();
    drain_results();
  endtask

  // The output stops for a long stretch while samples keep coming, so the row
  // fills and the input has to stall; then the sender waits for every result.
  task automatic test_output_hold_off();
    send_steady  = 1'b1;
    hold_request = HOLD_OFF_LONG;
    repeat (60) send_random_item();
    send_steady = 1'b0;
    drain_results();
  endtask

  task automatic test_steady_stream();
    send_steady = 1'b1;
    recv_steady = 1'b1;
    repeat (100) send_random_item();
    send_steady = 1'b0;
    recv_steady = 1'b0;
    drain_results();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_mix(600);
    test_output_hold_off();
    test_steady_stream();
    test_random_mix(660);
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && degree_queue.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
